// ===== rtl/core/btop_pkg.sv =====
`timescale 1ns / 1ps
package btop_pkg;

    localparam int PRICE_W   = 48;
    localparam int FACT_W    = 32;
    localparam int PROB_W    = 31;
    localparam int STEPS_W   = 11;
    localparam int HALF_W    = 24;
    localparam int ACC_W     = 80;
    localparam int CFG_IDX_W = 3;

    localparam logic [PROB_W-1:0]  ONE_Q30    = 31'h4000_0000;
    localparam logic [STEPS_W-1:0] STEPS_RST  = 11'd1;
    localparam logic [FACT_W-1:0]  UP_RST     = 32'd1181116006;
    localparam logic [FACT_W-1:0]  DOWN_RST   = 32'd976128930;
    localparam logic [PROB_W-1:0]  PROB_RST   = 31'd536870912;
    localparam logic [PROB_W-1:0]  DISC_RST   = 31'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TREE_STEPS = 3'd0,
        CFG_UP_FACTOR  = 3'd1,
        CFG_DOWN_FACTOR = 3'd2,
        CFG_UP_PROB    = 3'd3,
        CFG_DISCOUNT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        A_X,
        A_CUR,
        A_VDN,
        A_BLEND
    } a_sel_t;

    typedef enum logic [2:0] {
        F_DOWN,
        F_UP,
        F_P,
        F_Q,
        F_DISC
    } f_sel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DWRITE,
        S_DMUL_LO,
        S_DMUL_HI,
        S_DRND,
        S_COL_RD,
        S_COL_LD,
        S_SWRITE,
        S_SMUL_LO,
        S_SMUL_HI,
        S_SRND,
        S_PAY,
        S_VRD,
        S_BL0,
        S_BL1,
        S_BL2,
        S_BL3,
        S_BRND,
        S_SC0,
        S_SC1,
        S_NODE,
        S_VWJ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic   load;
        logic   mac;
        logic   mac_clr;
        logic   mac_hi;
        a_sel_t a_sel;
        f_sel_t f_sel;
        logic   x_round;
        logic   x_from_down;
        logic   blend_round;
        logic   cur_payoff;
        logic   node_update;
        logic   dn_we;
        logic   st_we;
        logic   vw_cur_j;
        logic   k_inc;
        logic   k_dec;
        logic   k_from_j;
        logic   j_from_n;
        logic   j_dec;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic k_eq_n;
        logic k_eq_j;
        logic j_zero;
        logic out_full;
    } stat_t;

endpackage

// ===== rtl/core/btop_ctrl.sv =====
`timescale 1ns / 1ps
module btop_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output btop_pkg::cmd_t cmd,
    input  btop_pkg::stat_t stat
);
    import btop_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_DWRITE;
            S_DWRITE:  state_next = stat.k_eq_n ? S_COL_RD : S_DMUL_LO;
            S_DMUL_LO: state_next = S_DMUL_HI;
            S_DMUL_HI: state_next = S_DRND;
            S_DRND:    state_next = S_DWRITE;
            S_COL_RD:  state_next = S_COL_LD;
            S_COL_LD:  state_next = S_SWRITE;
            S_SWRITE:  state_next = stat.k_eq_n ? S_PAY : S_SMUL_LO;
            S_SMUL_LO: state_next = S_SMUL_HI;
            S_SMUL_HI: state_next = S_SRND;
            S_SRND:    state_next = S_SWRITE;
            S_PAY:     state_next = stat.k_eq_j ? S_VWJ : S_VRD;
            S_VRD:     state_next = S_BL0;
            S_BL0:     state_next = S_BL1;
            S_BL1:     state_next = S_BL2;
            S_BL2:     state_next = S_BL3;
            S_BL3:     state_next = S_BRND;
            S_BRND:    state_next = S_SC0;
            S_SC0:     state_next = S_SC1;
            S_SC1:     state_next = S_NODE;
            S_NODE:    state_next = stat.k_eq_j ? S_VWJ : S_VRD;
            S_VWJ:     state_next = stat.j_zero ? S_DONE : S_COL_RD;
            S_DONE:    if (!stat.out_full) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DWRITE:
            begin
                cmd.dn_we    = 1'b1;
                cmd.j_from_n = stat.k_eq_n;
                cmd.k_inc    = !stat.k_eq_n;
            end
            S_DMUL_LO:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_clr = 1'b1;
                cmd.a_sel   = A_X;
                cmd.f_sel   = F_DOWN;
            end
            S_DMUL_HI:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_hi = 1'b1;
                cmd.a_sel  = A_X;
                cmd.f_sel  = F_DOWN;
            end
            S_DRND:    cmd.x_round = 1'b1;
            S_COL_RD:  cmd.k_from_j = 1'b1;
            S_COL_LD:  cmd.x_from_down = 1'b1;
            S_SWRITE:
            begin
                cmd.st_we = 1'b1;
                cmd.k_inc = !stat.k_eq_n;
            end
            S_SMUL_LO:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_clr = 1'b1;
                cmd.a_sel   = A_X;
                cmd.f_sel   = F_UP;
            end
            S_SMUL_HI:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_hi = 1'b1;
                cmd.a_sel  = A_X;
                cmd.f_sel  = F_UP;
            end
            S_SRND:    cmd.x_round = 1'b1;
            S_PAY:
            begin
                cmd.cur_payoff = 1'b1;
                cmd.k_dec      = !stat.k_eq_j;
            end
            S_VRD:     cmd = '0;
            S_BL0:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_clr = 1'b1;
                cmd.a_sel   = A_CUR;
                cmd.f_sel   = F_P;
            end
            S_BL1:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_hi = 1'b1;
                cmd.a_sel  = A_CUR;
                cmd.f_sel  = F_P;
            end
            S_BL2:
            begin
                cmd.mac   = 1'b1;
                cmd.a_sel = A_VDN;
                cmd.f_sel = F_Q;
            end
            S_BL3:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_hi = 1'b1;
                cmd.a_sel  = A_VDN;
                cmd.f_sel  = F_Q;
            end
            S_BRND:    cmd.blend_round = 1'b1;
            S_SC0:
            begin
                cmd.mac     = 1'b1;
                cmd.mac_clr = 1'b1;
                cmd.a_sel   = A_BLEND;
                cmd.f_sel   = F_DISC;
            end
            S_SC1:
            begin
                cmd.mac    = 1'b1;
                cmd.mac_hi = 1'b1;
                cmd.a_sel  = A_BLEND;
                cmd.f_sel  = F_DISC;
            end
            S_NODE:
            begin
                cmd.node_update = 1'b1;
                cmd.k_dec       = !stat.k_eq_j;
            end
            S_VWJ:
            begin
                cmd.vw_cur_j = 1'b1;
                cmd.j_dec    = !stat.j_zero;
            end
            S_DONE:    cmd.out_load = !stat.out_full;
            default:   cmd = '0;
        endcase
    end

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !stat.out_full)
        else $error("result loaded over an unread word");

    a_k_low: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.k_dec |-> !stat.k_eq_j)
        else $error("node index stepped below its column");

    a_k_high: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.k_inc |-> !stat.k_eq_n)
        else $error("node index stepped past the last level");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new word taken while an option is in progress");

endmodule

// ===== rtl/core/btop_dpath.sv =====
`timescale 1ns / 1ps
module btop_dpath #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [btop_pkg::CFG_IDX_W-1:0]              cfg_index,
    input  logic [btop_pkg::FACT_W-1:0]                 cfg_data,
    input  logic [2*btop_pkg::PRICE_W-1:0]              in_data,
    input  logic [1:0]                                  in_user,
    input  btop_pkg::cmd_t                              cmd,
    output btop_pkg::stat_t                             stat,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [btop_pkg::PRICE_W-1:0]                out_data,
    output logic                                        out_user
);
    import btop_pkg::*;

    localparam int IDX_W = $clog2(MAX_STEPS + 1);
    localparam int DEPTH = MAX_STEPS + 1;
    localparam logic [ACC_W:0] RND_HALF = {{(ACC_W - 29){1'b0}}, 1'b1, 29'b0};

    function automatic logic [PRICE_W-1:0] payoff(
        input logic [PRICE_W-1:0] s,
        input logic [PRICE_W-1:0] x,
        input logic               put
    );
        logic [PRICE_W-1:0] r;
        begin
            r = '0;
            if (put)
            begin
                if (x > s) r = x - s;
            end
            else
            begin
                if (s > x) r = s - x;
            end
            return r;
        end
    endfunction

    logic [STEPS_W-1:0] steps_reg;
    logic [FACT_W-1:0]  up_reg;
    logic [FACT_W-1:0]  down_reg;
    logic [PROB_W-1:0]  prob_reg;
    logic [PROB_W-1:0]  disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_RST;
            up_reg    <= UP_RST;
            down_reg  <= DOWN_RST;
            prob_reg  <= PROB_RST;
            disc_reg  <= DISC_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TREE_STEPS:  steps_reg <= cfg_data[STEPS_W-1:0];
                CFG_UP_FACTOR:   up_reg    <= cfg_data;
                CFG_DOWN_FACTOR: down_reg  <= cfg_data;
                CFG_UP_PROB:     prob_reg  <= cfg_data[PROB_W-1:0];
                CFG_DISCOUNT:    disc_reg  <= cfg_data[PROB_W-1:0];
                default:         steps_reg <= steps_reg;
            endcase
        end
    end

    logic [31:0]       steps_ext;
    logic [IDX_W-1:0]  n_eff;
    logic [PROB_W-1:0] p_eff;
    logic [PROB_W-1:0] q_eff;
    logic [PROB_W-1:0] d_eff;

    assign steps_ext = {{(32 - STEPS_W){1'b0}}, steps_reg};
    assign n_eff = (steps_ext > 32'(MAX_STEPS)) ? IDX_W'(MAX_STEPS) : IDX_W'(steps_ext);
    assign p_eff = (prob_reg > ONE_Q30) ? ONE_Q30 : prob_reg;
    assign q_eff = ONE_Q30 - p_eff;
    assign d_eff = (disc_reg > ONE_Q30) ? ONE_Q30 : disc_reg;

    logic [PRICE_W-1:0] strike_reg;
    logic               put_reg;
    logic               amer_reg;
    logic [PRICE_W-1:0] x_reg;
    logic [PRICE_W-1:0] x_next;
    logic [PRICE_W-1:0] cur_reg;
    logic [PRICE_W-1:0] cur_next;
    logic [PRICE_W-1:0] blend_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic               sat_reg;
    logic               sat_next;
    logic [IDX_W-1:0]   k_reg;
    logic [IDX_W-1:0]   k_next;
    logic [IDX_W-1:0]   j_reg;
    logic [IDX_W-1:0]   j_next;
    logic [PRICE_W-1:0] dn_rd_reg;
    logic [PRICE_W-1:0] st_rd_reg;
    logic [PRICE_W-1:0] vdn_rd_reg;

    logic [PRICE_W-1:0] a_op;
    logic [FACT_W-1:0]  f_op;
    logic [HALF_W-1:0]  a_part;
    logic [HALF_W+FACT_W-1:0] prod;
    logic [ACC_W-1:0]   prod_sh;
    logic [ACC_W:0]     rnd_sum;
    logic [ACC_W-30:0]  rnd;
    logic               sat_hit;
    logic [PRICE_W-1:0] rnd_price;
    logic [PRICE_W-1:0] pay_x;
    logic [PRICE_W-1:0] pay_st;
    logic [PRICE_W-1:0] node_v;
    logic [IDX_W-1:0]   k_plus1;
    logic [IDX_W-1:0]   vrd_addr;
    logic [IDX_W-1:0]   vwr_addr;

    always_comb
    begin
        case (cmd.a_sel)
            A_X:     a_op = x_reg;
            A_CUR:   a_op = cur_reg;
            A_VDN:   a_op = vdn_rd_reg;
            A_BLEND: a_op = blend_reg;
            default: a_op = x_reg;
        endcase
        case (cmd.f_sel)
            F_DOWN:  f_op = down_reg;
            F_UP:    f_op = up_reg;
            F_P:     f_op = {1'b0, p_eff};
            F_Q:     f_op = {1'b0, q_eff};
            F_DISC:  f_op = {1'b0, d_eff};
            default: f_op = '0;
        endcase
    end

    assign a_part  = cmd.mac_hi ? a_op[PRICE_W-1:HALF_W] : a_op[HALF_W-1:0];
    assign prod    = {{FACT_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, f_op};
    assign prod_sh = cmd.mac_hi ? {prod, {HALF_W{1'b0}}} : {{HALF_W{1'b0}}, prod};
    assign acc_next = cmd.mac ? ((cmd.mac_clr ? '0 : acc_reg) + prod_sh) : acc_reg;

    assign rnd_sum   = {1'b0, acc_reg} + RND_HALF;
    assign rnd       = rnd_sum[ACC_W:30];
    assign sat_hit   = |rnd[ACC_W-30:PRICE_W];
    assign rnd_price = sat_hit ? '1 : rnd[PRICE_W-1:0];

    assign pay_x  = payoff(x_reg, strike_reg, put_reg);
    assign pay_st = payoff(st_rd_reg, strike_reg, put_reg);
    assign node_v = (amer_reg && (pay_st > rnd[PRICE_W-1:0])) ? pay_st : rnd[PRICE_W-1:0];

    assign k_plus1  = k_reg + IDX_W'(1);
    assign vrd_addr = (k_reg == n_eff) ? k_reg : k_plus1;
    assign vwr_addr = cmd.vw_cur_j ? j_reg : k_plus1;

    always_comb
    begin
        x_next = x_reg;
        if (cmd.load)
        begin
            x_next = in_data[PRICE_W-1:0];
        end
        else if (cmd.x_round)
        begin
            x_next = rnd_price;
        end
        else if (cmd.x_from_down)
        begin
            x_next = dn_rd_reg;
        end

        sat_next = sat_reg;
        if (cmd.load)
        begin
            sat_next = 1'b0;
        end
        else if (cmd.x_round && sat_hit)
        begin
            sat_next = 1'b1;
        end

        cur_next = cur_reg;
        if (cmd.cur_payoff)
        begin
            cur_next = pay_x;
        end
        else if (cmd.node_update)
        begin
            cur_next = node_v;
        end

        k_next = k_reg;
        if (cmd.load)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_plus1;
        end
        else if (cmd.k_dec)
        begin
            k_next = k_reg - IDX_W'(1);
        end
        else if (cmd.k_from_j)
        begin
            k_next = j_reg;
        end

        j_next = j_reg;
        if (cmd.j_from_n)
        begin
            j_next = n_eff;
        end
        else if (cmd.j_dec)
        begin
            j_next = j_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        sat_reg <= sat_next;
        cur_reg <= cur_next;
        acc_reg <= acc_next;
        if (cmd.blend_round)
        begin
            blend_reg <= rnd[PRICE_W-1:0];
        end
        if (cmd.load)
        begin
            strike_reg <= in_data[2*PRICE_W-1:PRICE_W];
            put_reg    <= in_user[0];
            amer_reg   <= in_user[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            k_reg <= k_next;
            j_reg <= j_next;
        end
    end

    // Row stores: powers of d times spot, stock prices of one column, option values.
    logic [PRICE_W-1:0] down_row_mem  [DEPTH];
    logic [PRICE_W-1:0] stock_row_mem [DEPTH];
    logic [PRICE_W-1:0] value_row_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (cmd.dn_we)
        begin
            down_row_mem[k_reg] <= x_reg;
        end
        dn_rd_reg <= down_row_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.st_we)
        begin
            stock_row_mem[k_reg] <= x_reg;
        end
        st_rd_reg <= stock_row_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.node_update || cmd.vw_cur_j)
        begin
            value_row_mem[vwr_addr] <= cur_reg;
        end
        vdn_rd_reg <= value_row_mem[vrd_addr];
    end

    logic               out_valid_reg;
    logic [PRICE_W-1:0] out_price_reg;
    logic               out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_price_reg <= cur_reg;
            out_sat_reg   <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_price_reg;
    assign out_user  = out_sat_reg;

    assign stat.k_eq_n   = (k_reg == n_eff);
    assign stat.k_eq_j   = (k_reg == j_reg);
    assign stat.j_zero   = (j_reg == '0);
    assign stat.out_full = out_valid_reg;

    a_sat_only_round: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.load && !$past(cmd.x_round) && $past(!cmd.load) && sat_reg) |-> $past(sat_reg))
        else $error("saturation flag set outside a price product");

    a_clr_not_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mac && cmd.mac_clr) |-> !cmd.mac_hi)
        else $error("accumulator cleared on an upper partial product");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.node_update || cmd.st_we) |-> (k_reg <= n_eff))
        else $error("row index beyond the tree depth");

endmodule

// ===== rtl/core/binomial_tree_option_pricer.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Contents
// s_*       in         tvalid/tready      one option word per transfer
// m_*       out        tvalid/tready      root option value per option
// cfg_*     in         cfg_we strobe      tree and factor registers
//
// A single 24x32 multiplier forms every price,
// blend and discount product in partial products, one per cycle.
// After reset the configuration registers hold their documented defaults; the row stores need no clearing.
// The input is taken only when no option is in progress; a finished result waits
// in the output register while the next option is taken and computed.
module binomial_tree_option_pricer #(
    parameter int MAX_STEPS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [2*btop_pkg::PRICE_W-1:0]       s_tdata,  // spot_price, strike_price
    input  logic [1:0]                           s_tuser,  // is_put, is_american
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [btop_pkg::PRICE_W-1:0]         m_tdata,  // option_price
    output logic [0:0]                           m_tuser,  // saturated
    input  logic                                 cfg_we,
    input  logic [btop_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btop_pkg::FACT_W-1:0]          cfg_data
);
    import btop_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  sat_bit;

    btop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    btop_dpath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (sat_bit)
    );

    assign m_tuser[0] = sat_bit;

endmodule
